>>> rtl/vas_pkg.sv
// vas_pkg: shared types and constants for the voice allocator with stealing
// used by voice_allocate_steal, vas_alloc and vas_checker; no dependencies
`default_nettype none

package vas_pkg;

  // default number of voices and field widths
  localparam int VOICE_COUNT_DEF = 4;
  localparam int AGE_W = 16;
  localparam int CONTENT_W = 32;

  // command codes
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // behaviour byte that marks stream content
  localparam logic [7:0] STREAM_BEHAVIOUR = 8'd2;

  // request transaction
  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  slot;
    logic        busy_req;
    logic [31:0] content_spec;
    logic [15:0] splice;
    logic [7:0]  choke_group;
    logic [7:0]  valid_flag;
    logic [7:0]  behaviour_code;
    logic [3:0]  mixer_output;
  } req_t;

  // result transaction
  typedef struct packed {
    logic       granted;
    logic [1:0] grant_slot;
    logic       duplicate;
    logic [3:0] release_mask;
  } rsp_t;

  // stored entry attributes, 44 bits, splice in the low bits
  typedef struct packed {
    logic [3:0]  mixer;
    logic [7:0]  behaviour;
    logic [7:0]  valid;
    logic [7:0]  choke;
    logic [15:0] splice;
  } attr_t;

endpackage

`default_nettype wire

>>> rtl/vas_alloc.sv
// vas_alloc: one-pass allocation decision (duplicate check, free voice, steal)
// depends on vas_pkg
`default_nettype none

module vas_alloc import vas_pkg::*; #(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF,
  localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  logic [VOICE_COUNT-1:0] busy,
  input  logic [AGE_W-1:0]       age     [VOICE_COUNT],
  input  logic [CONTENT_W-1:0]   content [VOICE_COUNT],
  input  attr_t                  attr    [VOICE_COUNT],
  input  req_t                   req,
  output rsp_t                   rsp,
  output logic [IDX_W-1:0]       pick
);

  // request attributes packed as stored
  attr_t req_attr;
  assign req_attr = '{mixer: req.mixer_output, behaviour: req.behaviour_code,
                      valid: req.valid_flag, choke: req.choke_group,
                      splice: req.splice};

  always_comb begin
    logic                   have_free;
    logic [IDX_W-1:0]       free_idx;
    logic                   have_cand;
    logic [IDX_W-1:0]       cand_idx;
    logic [AGE_W-1:0]       best_age;
    logic                   stop;
    logic                   grant;
    logic [VOICE_COUNT-1:0] rmask;
    logic [31:0]            rmask_wide;
    logic [31:0]            pick_wide;

    have_free = 1'b0;
    free_idx  = '0;
    have_cand = 1'b0;
    cand_idx  = '0;
    best_age  = '0;
    stop      = 1'b0;
    grant     = 1'b0;
    rmask     = '0;
    pick      = '0;

    // lowest free voice
    for (int v = 0; v < VOICE_COUNT; v++) begin
      if (!busy[v] && !have_free) begin
        have_free = 1'b1;
        free_idx  = IDX_W'(v);
      end
    end

    // walk voices: duplicate stops the walk, choke and age pick a candidate
    for (int v = 0; v < VOICE_COUNT; v++) begin
      if (!stop) begin
        if (busy[v] && req.behaviour_code == STREAM_BEHAVIOUR
            && attr[v].behaviour == STREAM_BEHAVIOUR
            && content[v] == req.content_spec && attr[v] == req_attr) begin
          stop = 1'b1;
        end else if (attr[v].choke != 8'd0) begin
          if (attr[v].choke == req.choke_group) begin
            rmask[v]  = 1'b1;
            have_cand = 1'b1;
            cand_idx  = IDX_W'(v);
          end else if (attr[v].choke < req.choke_group) begin
            have_cand = 1'b1;
            cand_idx  = IDX_W'(v);
          end
        end else if (age[v] > best_age) begin
          best_age  = age[v];
          have_cand = 1'b1;
          cand_idx  = IDX_W'(v);
        end
      end
    end

    // final choice
    if (!stop) begin
      if (have_free) begin
        grant = 1'b1;
        pick  = free_idx;
      end else if (have_cand) begin
        grant           = 1'b1;
        pick            = cand_idx;
        rmask[cand_idx] = 1'b1;
      end
    end

    rmask_wide = 32'(rmask);
    pick_wide  = 32'(pick);

    // results exist only for allocate requests
    if (req.command == CMD_ALLOC) begin
      rsp.granted      = grant;
      rsp.grant_slot   = grant ? pick_wide[1:0] : 2'd0;
      rsp.duplicate    = stop;
      rsp.release_mask = rmask_wide[3:0];
    end else begin
      rsp = '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/voice_allocate_steal.sv
// voice_allocate_steal: top level, one request stage, voice state, result register
// An accepted transaction passes from the request stage to the result register.
// Throughput: one transaction per cycle while no result is stalled; state is
// updated as the item leaves the request stage, so the next item sees it at once.
// Reset (rst, synchronous): all voices free, ages, entries and valids cleared.
// depends on vas_pkg and vas_alloc
`default_nettype none

module voice_allocate_steal import vas_pkg::*; #(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  // request stage
  logic a_valid;
  req_t a_req;

  // voice state
  logic [VOICE_COUNT-1:0] busy;
  logic [AGE_W-1:0]       age     [VOICE_COUNT];
  logic [CONTENT_W-1:0]   content [VOICE_COUNT];
  attr_t                  attr    [VOICE_COUNT];

  rsp_t             alloc_rsp;
  logic [IDX_W-1:0] pick;
  logic             advance;
  logic [31:0]      slot_wide;
  logic [IDX_W-1:0] slot_idx;
  logic             slot_ok;

  vas_alloc #(.VOICE_COUNT(VOICE_COUNT)) u_alloc (
    .busy    (busy),
    .age     (age),
    .content (content),
    .attr    (attr),
    .req     (a_req),
    .rsp     (alloc_rsp),
    .pick    (pick)
  );

  // stage moves on when the result register is empty or being taken
  assign advance   = a_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = a_valid && !advance;

  assign slot_wide = 32'(a_req.slot);
  assign slot_idx  = slot_wide[IDX_W-1:0];
  assign slot_ok   = slot_wide < 32'(VOICE_COUNT);

  // request stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
    if (req_valid && !req_stall) begin
      a_req <= req;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (advance) begin
      rsp <= alloc_rsp;
    end
  end

  // voice state update
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        age[v]     <= '0;
        content[v] <= '0;
        attr[v]    <= '0;
      end
    end else if (advance) begin
      case (a_req.command)
        CMD_REPORT: begin
          if (slot_ok) begin
            busy[slot_idx] <= a_req.busy_req;
          end
        end
        CMD_TICK: begin
          for (int v = 0; v < VOICE_COUNT; v++) begin
            age[v] <= busy[v] ? age[v] + 16'd1 : '0;
          end
        end
        CMD_ALLOC: begin
          if (alloc_rsp.granted) begin
            busy[pick]    <= 1'b1;
            age[pick]     <= '0;
            content[pick] <= a_req.content_spec;
            attr[pick]    <= '{mixer: a_req.mixer_output,
                               behaviour: a_req.behaviour_code,
                               valid: a_req.valid_flag,
                               choke: a_req.choke_group,
                               splice: a_req.splice};
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/vas_checker.sv
// vas_checker: port-level assertions for voice_allocate_steal, with its bind
// depends on vas_pkg and the voice_allocate_steal port list
`default_nettype none

module vas_checker import vas_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // a grant and a duplicate never come together
  a_grant_not_dup: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.granted && rsp.duplicate))
    else $error("grant and duplicate in one result");

  // no grant means slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.granted) |-> (rsp.grant_slot == 2'd0))
    else $error("grant slot set without grant");

  // after reset nothing pending and requests are taken
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!rsp_valid && !req_stall))
    else $error("state not cleared by reset");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");

endmodule

bind voice_allocate_steal vas_checker u_vas_checker (.*);

`default_nettype wire

>>> tb/voice_allocate_steal_test.sv
// voice_allocate_steal_test: self-checking bench for the four-voice allocator with stealing
// drives allocate, report, tick and unused-command transactions, predicts each outcome, checks every result
// depends on vas_pkg and voice_allocate_steal
`timescale 1ns / 100ps

module voice_allocate_steal_test;
  import vas_pkg::*;

  localparam int VOICE_N = VOICE_COUNT_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // voice table predictor and the outcomes still owed by the block
  class voice_allocation_book;
    logic        busy [VOICE_N];
    logic [15:0] age [VOICE_N];
    logic [31:0] content [VOICE_N];
    attr_t       attr [VOICE_N];
    rsp_t        pending_outcomes [$];
    int          mismatches;

    function new();
      for (int v = 0; v < VOICE_N; v++) begin
        busy[v] = 1'b0;
        age[v] = '0;
        content[v] = '0;
        attr[v] = '0;
      end
      mismatches = 0;
    endfunction

    // apply one accepted transaction to the voice table and queue its outcome
    function void note_request(req_t item);
      rsp_t        want;
      attr_t       ask;
      int          free_voice;
      int          steal;
      int          pick;
      logic [15:0] oldest;
      want = '0;
      case (item.command)
        CMD_REPORT: begin
          busy[item.slot] = item.busy_req;
        end
        CMD_TICK: begin
          for (int v = 0; v < VOICE_N; v++)
            age[v] = busy[v] ? age[v] + 16'd1 : 16'd0;
        end
        CMD_ALLOC: begin
          ask.splice = item.splice;
          ask.choke = item.choke_group;
          ask.valid = item.valid_flag;
          ask.behaviour = item.behaviour_code;
          ask.mixer = item.mixer_output;
          free_voice = -1;
          steal = -1;
          oldest = '0;
          for (int v = VOICE_N - 1; v >= 0; v--)
            if (!busy[v]) free_voice = v;
          // walk voices low to high, stop on a playing copy of the same stream
          for (int v = 0; v < VOICE_N && !want.duplicate; v++) begin
            if (busy[v] && item.behaviour_code == STREAM_BEHAVIOUR
                && attr[v].behaviour == STREAM_BEHAVIOUR
                && content[v] == item.content_spec && attr[v] == ask) begin
              want.duplicate = 1'b1;
            end else if (attr[v].choke != 8'd0) begin
              if (attr[v].choke == item.choke_group) begin
                want.release_mask[v] = 1'b1;
                steal = v;
              end else if (attr[v].choke < item.choke_group) begin
                steal = v;
              end
            end else if (age[v] > oldest) begin
              oldest = age[v];
              steal = v;
            end
          end
          if (!want.duplicate) begin
            pick = (free_voice >= 0) ? free_voice : steal;
            if (free_voice < 0 && steal >= 0) want.release_mask[steal[1:0]] = 1'b1;
            if (pick >= 0) begin
              want.granted = 1'b1;
              want.grant_slot = pick[1:0];
              content[pick] = item.content_spec;
              attr[pick] = ask;
              age[pick] = '0;
              busy[pick] = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      pending_outcomes.push_back(want);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // compare one accepted result against the oldest queued outcome
    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_outcomes.size() == 0) begin
        $error("result with no transaction outstanding: %p", got);
        mismatches++;
        return;
      end
      want = pending_outcomes.pop_front();
      compare_field("granted", want.granted, got.granted);
      compare_field("grant_slot", want.grant_slot, got.grant_slot);
      compare_field("duplicate", want.duplicate, got.duplicate);
      compare_field("release_mask", want.release_mask, got.release_mask);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t request = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t result;

  voice_allocation_book book = new();
  bit flat_out = 1'b0;
  int sender_quiet = 0;
  int drain_quiet = 0;

  voice_allocate_steal dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (request),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // idle cycles before the next transaction, with quiet stretches now and then
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // random fill for every field, command fixed
  function automatic req_t noise_req(logic [1:0] cmd);
    req_t item;
    item.command = cmd;
    item.slot = 2'($urandom_range(0, 3));
    item.busy_req = 1'($urandom_range(0, 1));
    item.content_spec = $urandom();
    item.splice = 16'($urandom_range(0, 65535));
    item.choke_group = 8'($urandom_range(0, 255));
    item.valid_flag = 8'($urandom_range(0, 255));
    item.behaviour_code = 8'($urandom_range(0, 255));
    item.mixer_output = 4'($urandom_range(0, 9));
    return item;
  endfunction

  function automatic req_t alloc_req(logic [31:0] content, logic [15:0] splice,
                                     logic [7:0] choke, logic [7:0] valid,
                                     logic [7:0] behaviour, logic [3:0] mixer);
    req_t item;
    item = noise_req(CMD_ALLOC);
    item.content_spec = content;
    item.splice = splice;
    item.choke_group = choke;
    item.valid_flag = valid;
    item.behaviour_code = behaviour;
    item.mixer_output = mixer;
    return item;
  endfunction

  function automatic req_t report_req(logic [1:0] slot, logic busy);
    req_t item;
    item = noise_req(CMD_REPORT);
    item.slot = slot;
    item.busy_req = busy;
    return item;
  endfunction

  // offer one transaction and hold it until accepted
  task automatic send_request(input req_t item);
    int gap;
    gap = flat_out ? 0 : draw_wait(sender_quiet);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    request <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    book.note_request(item);
  endtask

  // result side: random stalls, one long hold-off once the run is under way
  initial begin : drain
    int hold;
    int results_taken;
    bit held_back;
    results_taken = 0;
    held_back = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_back && results_taken >= 300) begin
        hold = 120;
        held_back = 1'b1;
      end else begin
        hold = flat_out ? 0 : draw_wait(drain_quiet);
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rst || !rsp_valid);
      results_taken++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) book.check_result(result);
  end

  initial begin : stimulus
    req_t       item;
    req_t       recent [8];
    req_t       stolen_stream;
    req_t       freed_entry;
    int         pick;
    logic [2:0] slot_pick;
    for (int i = 0; i < 8; i++) recent[i] = noise_req(CMD_ALLOC);
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // tick with every voice free, then a stream and a playing copy of it
    send_request(noise_req(CMD_TICK));
    send_request(alloc_req(32'h0, 16'h0, 8'd0, 8'h00, STREAM_BEHAVIOUR, 4'd0));
    send_request(alloc_req(32'h0, 16'h0, 8'd0, 8'h00, STREAM_BEHAVIOUR, 4'd0));
    // field extremes, then fill the remaining voices
    send_request(alloc_req('1, '1, '1, '1, '1, 4'd9));
    send_request(alloc_req(32'h3, 16'h3, 8'd3, 8'h01, 8'd0, 4'd8));
    repeat (3) send_request(noise_req(CMD_TICK));
    send_request(alloc_req(32'h5, 16'h5, 8'd1, 8'h01, STREAM_BEHAVIOUR, 4'd1));
    send_request(noise_req(CMD_TICK));
    // all busy: same group released, last lower group stolen
    stolen_stream = alloc_req(32'h9, 16'h9, 8'd3, 8'h01, STREAM_BEHAVIOUR, 4'd2);
    send_request(stolen_stream);
    // free voice granted while same-group releases are still reported
    send_request(report_req(2'd1, 1'b0));
    freed_entry = alloc_req(32'hb, 16'hb, 8'd3, 8'h01, 8'd0, 4'd3);
    send_request(freed_entry);
    // releases walked before the duplicate are kept
    send_request(stolen_stream);
    // same entry without stream behaviour is no duplicate
    send_request(freed_entry);
    // oldest group-0 voice stolen, then nothing left to steal
    send_request(alloc_req(32'h7, 16'h7, 8'd0, 8'h01, 8'd0, 4'd4));
    send_request(alloc_req(32'h8, 16'h8, 8'd0, 8'h01, 8'd0, 4'd5));
    // unused command and reports
    send_request(noise_req(CMD_UNUSED));
    send_request(report_req(2'd3, 1'b1));
    send_request(report_req(2'd2, 1'b0));
    send_request(noise_req(CMD_TICK));

    // random traffic over a small set of entries so duplicates and steals recur
    for (int n = 0; n < 760; n++) begin
      pick = $urandom_range(0, 99);
      slot_pick = 3'($urandom_range(0, 7));
      if (pick < 18) begin
        item = recent[slot_pick];
      end else if (pick < 28) begin
        item = recent[slot_pick];
        case ($urandom_range(0, 5))
          0: item.content_spec ^= 32'd1 << $urandom_range(0, 31);
          1: item.splice ^= 16'd1 << $urandom_range(0, 15);
          2: item.choke_group ^= 8'd1 << $urandom_range(0, 7);
          3: item.valid_flag ^= 8'd1 << $urandom_range(0, 7);
          4: item.behaviour_code ^= 8'd1 << $urandom_range(0, 7);
          default: item.mixer_output = 4'($urandom_range(0, 9));
        endcase
      end else if (pick < 50) begin
        item = noise_req(CMD_ALLOC);
        if ($urandom_range(0, 3) != 0) begin
          item.content_spec = $urandom_range(0, 3);
          item.splice = 16'($urandom_range(0, 3));
          item.valid_flag = 8'($urandom_range(0, 1));
        end
        case ($urandom_range(0, 5))
          0, 1: item.choke_group = 8'd0;
          2: item.choke_group = 8'd1;
          3: item.choke_group = 8'd2;
          4: item.choke_group = 8'd3;
          default: begin
          end
        endcase
        if ($urandom_range(0, 4) < 3) item.behaviour_code = STREAM_BEHAVIOUR;
        recent[slot_pick] = item;
      end else if (pick < 72) begin
        item = report_req(2'($urandom_range(0, 3)), $urandom_range(0, 9) < 7);
      end else if (pick < 97) begin
        item = noise_req(CMD_TICK);
      end else begin
        item = noise_req(CMD_UNUSED);
      end
      send_request(item);
    end

    // back-to-back burst: all voices playing, ticks, then steals of the oldest
    flat_out = 1'b1;
    for (int s = 0; s < VOICE_N; s++) send_request(report_req(s[1:0], 1'b1));
    send_request(noise_req(CMD_TICK));
    send_request(alloc_req($urandom(), 16'h0, 8'd0, 8'h0, 8'd0, 4'd0));
    repeat (16) send_request(noise_req(CMD_TICK));
    repeat (6) send_request(alloc_req($urandom(), 16'h1, 8'd0, 8'h0, 8'd0, 4'd6));
    flat_out = 1'b0;

    @(negedge clk);
    req_valid <= 1'b0;
    while (book.pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.mismatches == 0 && book.pending_outcomes.size() == 0) begin
      $display("[voice_allocate_steal] OK");
    end else begin
      $display("[voice_allocate_steal] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #500000;
    $display("[voice_allocate_steal] ERROR");
    $finish;
  end

endmodule
